### src/rcwt_pkg.sv
// Package with the shared types, codes and code decoder of the remote code whitelist table.
`timescale 1ns / 1ps
`default_nettype none

package rcwt_pkg;

    localparam int SLOT_COUNT_DEF = 16;
    localparam int BASE_W         = 28;
    localparam int REQ_W          = 2;
    localparam int SLOT_W         = 4;
    localparam int CODE_W         = 32;
    localparam int STATUS_W       = 3;
    localparam int BUTTON_W       = 3;

    typedef enum logic [REQ_W-1:0] {
        REQ_CHECK  = 2'd0,
        REQ_LEARN  = 2'd1,
        REQ_ENABLE = 2'd2,
        REQ_REMOVE = 2'd3
    } t_req_type;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_SLOT  = 3'd1,
        ST_BAD_CODE  = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_DISABLED  = 3'd4
    } t_status;

    localparam logic [3:0] CMD_NIB_1  = 4'h1;
    localparam logic [3:0] CMD_NIB_2  = 4'h2;
    localparam logic [3:0] CMD_NIB_3  = 4'h4;
    localparam logic [3:0] CMD_NIB_4  = 4'h8;
    localparam logic [7:0] CMD_BYTE_1 = 8'hC0;
    localparam logic [7:0] CMD_BYTE_2 = 8'h03;
    localparam logic [7:0] CMD_BYTE_3 = 8'h0C;
    localparam logic [7:0] CMD_BYTE_4 = 8'h30;

    typedef struct packed {
        logic                ok;
        logic [BUTTON_W-1:0] button;
        logic [BASE_W-1:0]   base;
    } t_decode;

    typedef struct packed {
        logic we_base;
        logic we_enable;
    } t_mem_wr;

    function automatic t_decode decode_code(input logic [CODE_W-1:0] code);
        t_decode d;
        d.button = '0;
        d.base   = '0;
        case (code[3:0])
            CMD_NIB_1: d.button = 3'd1;
            CMD_NIB_2: d.button = 3'd2;
            CMD_NIB_3: d.button = 3'd3;
            CMD_NIB_4: d.button = 3'd4;
            default:   d.button = '0;
        endcase
        if (d.button != '0) begin
            d.base = code[CODE_W-1:4];
        end else begin
            case (code[7:0])
                CMD_BYTE_1: d.button = 3'd1;
                CMD_BYTE_2: d.button = 3'd2;
                CMD_BYTE_3: d.button = 3'd3;
                CMD_BYTE_4: d.button = 3'd4;
                default:    d.button = '0;
            endcase
            if (d.button != '0) begin
                d.base = {4'b0, code[CODE_W-1:8]};
            end
        end
        d.ok = (d.button != '0) && (d.base != '0);
        return d;
    endfunction

endpackage

`default_nettype wire

### src/rcwt_ifs.sv
// Valid-ready channel interfaces for the request and response items of the whitelist table.
`timescale 1ns / 1ps
`default_nettype none

interface rcwt_req_if;
    logic                          valid;
    logic                          ready;
    logic [rcwt_pkg::REQ_W-1:0]    req_type;
    logic [rcwt_pkg::SLOT_W-1:0]   slot_index;
    logic [rcwt_pkg::CODE_W-1:0]   raw_code;
    logic                          enable_flag;

    modport source (output valid, req_type, slot_index, raw_code, enable_flag, input ready);
    modport sink   (input valid, req_type, slot_index, raw_code, enable_flag, output ready);
endinterface

interface rcwt_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [rcwt_pkg::STATUS_W-1:0] status;
    logic [rcwt_pkg::BUTTON_W-1:0] button;
    logic [rcwt_pkg::SLOT_W-1:0]   matched_slot;

    modport source (output valid, status, button, matched_slot, input ready);
    modport sink   (input valid, status, button, matched_slot, output ready);
endinterface

`default_nettype wire

### src/rcwt_slot_mem.sv
// Slot memories for base codes and enable bits, with per-entry valid bits cleared at reset.
`timescale 1ns / 1ps
`default_nettype none

module rcwt_slot_mem #(
    parameter int SLOT_COUNT = rcwt_pkg::SLOT_COUNT_DEF,
    parameter int AW         = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire rcwt_pkg::t_mem_wr           i_wr,
    input  wire logic [AW-1:0]               i_wr_addr,
    input  wire logic [rcwt_pkg::BASE_W-1:0] i_wr_base,
    input  wire logic                        i_wr_enable,
    input  wire logic                        i_rd_en,
    input  wire logic [AW-1:0]               i_rd_addr,
    output logic      [rcwt_pkg::BASE_W-1:0] o_rd_base,
    output logic                             o_rd_enable
);
    import rcwt_pkg::*;

    logic [BASE_W-1:0]     mem_base [SLOT_COUNT];
    logic                  mem_en   [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_base_vld;
    logic [SLOT_COUNT-1:0] r_en_vld;
    logic [BASE_W-1:0]     r_rd_base;
    logic                  r_rd_en;
    logic                  r_rd_base_vld;
    logic                  r_rd_en_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.we_base) begin
            mem_base[i_wr_addr] <= i_wr_base;
        end
        if (i_wr.we_enable) begin
            mem_en[i_wr_addr] <= i_wr_enable;
        end
        if (i_rd_en) begin
            r_rd_base     <= mem_base[i_rd_addr];
            r_rd_en       <= mem_en[i_rd_addr];
            r_rd_base_vld <= r_base_vld[i_rd_addr];
            r_rd_en_vld   <= r_en_vld[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_vld <= '0;
            r_en_vld   <= '0;
        end else begin
            if (i_wr.we_base) begin
                r_base_vld[i_wr_addr] <= 1'b1;
            end
            if (i_wr.we_enable) begin
                r_en_vld[i_wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_base   = r_rd_base_vld ? r_rd_base : '0;
    assign o_rd_enable = r_rd_en_vld & r_rd_en;

endmodule

`default_nettype wire

### src/remote_code_whitelist_table.sv
// Top level of the remote code whitelist table: request decode, slot scan and result register.
//
//  Channel | Dir | Payload                                          | Accepted when
//  i_req   | in  | req_type, slot_index, raw_code, enable_flag      | valid && ready
//  o_rsp   | out | status, button, matched_slot                     | valid && ready
//
// Learn, enable, remove and undecodable checks go from acceptance straight to the done state,
// which loads the result into the output register. A check scans the slot memory one entry
// per cycle through its single read port and ends early on a match.
// Reset clears the valid bits of every slot at once; the block is ready once reset is released.
// A new item is accepted while a result still waits in the output register; a stalled
// output only holds the block once the next result is ready.
`timescale 1ns / 1ps
`default_nettype none

module remote_code_whitelist_table #(
    parameter int SLOT_COUNT = rcwt_pkg::SLOT_COUNT_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rcwt_req_if.sink   i_req,
    rcwt_rsp_if.source o_rsp
);
    import rcwt_pkg::*;

    localparam int          AW   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [AW-1:0] LAST = AW'(SLOT_COUNT - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_addr, n_addr;
    logic                r_issue, n_issue;
    logic                r_cmp_pend, n_cmp_pend;
    logic [AW-1:0]       r_cmp_idx, n_cmp_idx;
    logic [BASE_W-1:0]   r_key, n_key;
    logic [BUTTON_W-1:0] r_btn, n_btn;
    t_status             r_res_status, n_res_status;
    logic [BUTTON_W-1:0] r_res_btn, n_res_btn;
    logic [SLOT_W-1:0]   r_res_slot, n_res_slot;
    logic                r_out_vld, n_out_vld;
    t_status             r_out_status, n_out_status;
    logic [BUTTON_W-1:0] r_out_btn, n_out_btn;
    logic [SLOT_W-1:0]   r_out_slot, n_out_slot;

    t_decode             w_dec;
    logic                w_acc;
    logic                w_bad_slot;
    t_mem_wr             w_wr;
    logic [BASE_W-1:0]   w_wr_base;
    logic                w_wr_enable;
    logic [BASE_W-1:0]   w_rd_base;
    logic                w_rd_enable;
    logic                w_hit;

    assign w_dec      = decode_code(i_req.raw_code);
    assign i_req.ready = i_rst_n && (r_state == S_IDLE);
    assign w_acc      = i_req.valid && i_req.ready;
    assign w_bad_slot = int'(i_req.slot_index) >= SLOT_COUNT;
    assign w_hit      = r_cmp_pend && (w_rd_base == r_key);

    rcwt_slot_mem #(
        .SLOT_COUNT (SLOT_COUNT),
        .AW         (AW)
    ) u_slot_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (w_wr),
        .i_wr_addr   (AW'(i_req.slot_index)),
        .i_wr_base   (w_wr_base),
        .i_wr_enable (w_wr_enable),
        .i_rd_en     ((r_state == S_SCAN) && r_issue),
        .i_rd_addr   (r_addr),
        .o_rd_base   (w_rd_base),
        .o_rd_enable (w_rd_enable)
    );

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_issue      = r_issue;
        n_cmp_pend   = 1'b0;
        n_cmp_idx    = r_cmp_idx;
        n_key        = r_key;
        n_btn        = r_btn;
        n_res_status = r_res_status;
        n_res_btn    = r_res_btn;
        n_res_slot   = r_res_slot;
        n_out_vld    = r_out_vld && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_btn    = r_out_btn;
        n_out_slot   = r_out_slot;
        w_wr         = '0;
        w_wr_base    = '0;
        w_wr_enable  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_state      = S_DONE;
                    n_res_status = ST_OK;
                    n_res_btn    = '0;
                    n_res_slot   = '0;
                    if (t_req_type'(i_req.req_type) == REQ_CHECK) begin
                        if (!w_dec.ok) begin
                            n_res_status = ST_BAD_CODE;
                        end else begin
                            n_state = S_SCAN;
                            n_key   = w_dec.base;
                            n_btn   = w_dec.button;
                            n_addr  = '0;
                            n_issue = 1'b1;
                        end
                    end else if (w_bad_slot) begin
                        n_res_status = ST_BAD_SLOT;
                    end else begin
                        unique case (t_req_type'(i_req.req_type))
                            REQ_LEARN: begin
                                if (!w_dec.ok) begin
                                    n_res_status = ST_BAD_CODE;
                                end else begin
                                    w_wr.we_base   = 1'b1;
                                    w_wr.we_enable = 1'b1;
                                    w_wr_base      = w_dec.base;
                                    w_wr_enable    = 1'b1;
                                end
                            end
                            REQ_ENABLE: begin
                                w_wr.we_enable = 1'b1;
                                w_wr_enable    = i_req.enable_flag;
                            end
                            REQ_REMOVE: begin
                                w_wr.we_base   = 1'b1;
                                w_wr.we_enable = 1'b1;
                            end
                            default: begin
                                n_res_status = ST_OK;
                            end
                        endcase
                    end
                end
            end
            S_SCAN: begin
                n_cmp_pend = r_issue;
                n_cmp_idx  = r_addr;
                if (r_issue) begin
                    if (r_addr == LAST) begin
                        n_issue = 1'b0;
                    end else begin
                        n_addr = r_addr + 1'b1;
                    end
                end
                if (w_hit) begin
                    n_state    = S_DONE;
                    n_issue    = 1'b0;
                    n_cmp_pend = 1'b0;
                    if (w_rd_enable) begin
                        n_res_status = ST_OK;
                        n_res_btn    = r_btn;
                        n_res_slot   = SLOT_W'(r_cmp_idx);
                    end else begin
                        n_res_status = ST_DISABLED;
                    end
                end else if (r_cmp_pend && (r_cmp_idx == LAST)) begin
                    n_state      = S_DONE;
                    n_issue      = 1'b0;
                    n_cmp_pend   = 1'b0;
                    n_res_status = ST_NOT_FOUND;
                end
            end
            S_DONE: begin
                if (!r_out_vld || o_rsp.ready) begin
                    n_out_vld    = 1'b1;
                    n_out_status = r_res_status;
                    n_out_btn    = r_res_btn;
                    n_out_slot   = r_res_slot;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_issue    <= 1'b0;
            r_cmp_pend <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_issue    <= n_issue;
            r_cmp_pend <= n_cmp_pend;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr       <= n_addr;
        r_cmp_idx    <= n_cmp_idx;
        r_key        <= n_key;
        r_btn        <= n_btn;
        r_res_status <= n_res_status;
        r_res_btn    <= n_res_btn;
        r_res_slot   <= n_res_slot;
        r_out_status <= n_out_status;
        r_out_btn    <= n_out_btn;
        r_out_slot   <= n_out_slot;
    end

    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.button       = r_out_btn;
    assign o_rsp.matched_slot = r_out_slot;

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> (r_state != S_IDLE))
        else $error("accepted item did not start work");

    a_button_only_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out_btn != '0)) |-> (r_out_status == ST_OK))
        else $error("button reported on a failed request");

    a_compare_only_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_pend |-> (r_state == S_SCAN))
        else $error("slot compare pending outside the scan");

    a_scan_issues_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && r_issue && (n_state == S_SCAN)) |=>
            (r_cmp_pend && (r_cmp_idx == $past(r_addr))))
        else $error("slot read and compare out of step");

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench of the remote code whitelist table: a directed table, then random requests.
`timescale 1ns / 1ps

module tb;
    import rcwt_pkg::*;

    localparam int NSLOT        = SLOT_COUNT_DEF;
    localparam int RANDOM_ITEMS = 1750;
    localparam int STALL_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 30;
    localparam int POOL_SIZE    = 8;

    typedef struct packed {
        t_req_type           req;
        logic [SLOT_W-1:0]   slot;
        logic [CODE_W-1:0]   code;
        logic                en;
    } t_request;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BUTTON_W-1:0] button;
        logic [SLOT_W-1:0]   slot;
    } t_answer;

    typedef struct packed {
        t_request req;
        logic     typed;
        t_answer  ans;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    rcwt_req_if req_if ();
    rcwt_rsp_if rsp_if ();

    remote_code_whitelist_table uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    logic [BASE_W-1:0] tbl_base  [NSLOT];
    logic              tbl_on    [NSLOT];
    logic [BASE_W-1:0] base_pool [POOL_SIZE];

    t_answer answer_q [$];
    t_row    dir_rows [$];

    int errors       = 0;
    int n_sent       = 0;
    int n_checks     = 0;
    int n_allowed    = 0;
    int n_learns     = 0;
    int n_writes     = 0;
    int quiet_cycles = 0;
    bit calm         = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [BUTTON_W-1:0] split_code(input logic [CODE_W-1:0] code,
                                                       output logic [BASE_W-1:0] base);
        logic [BUTTON_W-1:0] btn;
        btn  = '0;
        base = '0;
        case (code[3:0])
            CMD_NIB_1: btn = 3'd1;
            CMD_NIB_2: btn = 3'd2;
            CMD_NIB_3: btn = 3'd3;
            CMD_NIB_4: btn = 3'd4;
            default:   btn = '0;
        endcase
        if (btn != '0) begin
            base = code[CODE_W-1:4];
        end else begin
            case (code[7:0])
                CMD_BYTE_1: btn = 3'd1;
                CMD_BYTE_2: btn = 3'd2;
                CMD_BYTE_3: btn = 3'd3;
                CMD_BYTE_4: btn = 3'd4;
                default:    btn = '0;
            endcase
            if (btn != '0) begin
                base = {4'h0, code[CODE_W-1:8]};
            end
        end
        return btn;
    endfunction

    function automatic t_answer whitelist_answer(input t_request r);
        t_answer             a;
        logic [BASE_W-1:0]   base;
        logic [BUTTON_W-1:0] btn;
        int                  hit;
        int                  i;
        a        = '0;
        a.status = ST_OK;
        hit      = -1;
        btn      = split_code(r.code, base);
        if (r.req != REQ_CHECK && int'(r.slot) >= NSLOT) begin
            a.status = ST_BAD_SLOT;
        end else begin
            case (r.req)
                REQ_CHECK: begin
                    if (btn == '0 || base == '0) begin
                        a.status = ST_BAD_CODE;
                    end else begin
                        for (i = NSLOT - 1; i >= 0; i--) begin
                            if (tbl_base[i] == base) hit = i;
                        end
                        if (hit < 0) begin
                            a.status = ST_NOT_FOUND;
                        end else if (!tbl_on[hit]) begin
                            a.status = ST_DISABLED;
                        end else begin
                            a.button = btn;
                            a.slot   = hit[SLOT_W-1:0];
                        end
                    end
                end
                REQ_LEARN: begin
                    if (btn == '0 || base == '0) begin
                        a.status = ST_BAD_CODE;
                    end else begin
                        tbl_base[r.slot] = base;
                        tbl_on[r.slot]   = 1'b1;
                    end
                end
                REQ_ENABLE: begin
                    tbl_on[r.slot] = r.en;
                end
                default: begin
                    tbl_base[r.slot] = '0;
                    tbl_on[r.slot]   = 1'b0;
                end
            endcase
        end
        return a;
    endfunction

    function automatic logic [CODE_W-1:0] code_for(input logic [BASE_W-1:0] base);
        int         k;
        logic [7:0] cmd_byte;
        logic [3:0] cmd_nib;
        k = $urandom_range(3);
        case (k)
            0:       begin cmd_byte = CMD_BYTE_1; cmd_nib = CMD_NIB_1; end
            1:       begin cmd_byte = CMD_BYTE_2; cmd_nib = CMD_NIB_2; end
            2:       begin cmd_byte = CMD_BYTE_3; cmd_nib = CMD_NIB_3; end
            default: begin cmd_byte = CMD_BYTE_4; cmd_nib = CMD_NIB_4; end
        endcase
        if (base[BASE_W-1:24] == '0 && $urandom_range(1) == 1) begin
            return {base[23:0], cmd_byte};
        end
        return {base, cmd_nib};
    endfunction

    function automatic logic [BASE_W-1:0] pool_base(input int idx);
        logic [BASE_W-1:0] b;
        b = (idx < POOL_SIZE / 2) ? {4'h0, 24'($urandom)} : BASE_W'($urandom);
        if (b == '0) b = BASE_W'(idx + 1);
        return b;
    endfunction

    function automatic t_request random_request();
        t_request r;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 45) begin
            r.req = REQ_CHECK;
        end else if (pick < 70) begin
            r.req = REQ_LEARN;
        end else if (pick < 85) begin
            r.req = REQ_ENABLE;
        end else begin
            r.req = REQ_REMOVE;
        end
        r.slot = SLOT_W'($urandom_range(15));
        r.en   = 1'($urandom_range(1));
        pick   = $urandom_range(99);
        if (pick < 15) begin
            r.code = $urandom;
        end else if (pick < 19) begin
            r.code = code_for('0);
        end else begin
            r.code = code_for(base_pool[$urandom_range(POOL_SIZE - 1)]);
        end
        return r;
    endfunction

    task automatic add_row(input t_req_type q, input int s, input logic [CODE_W-1:0] c,
                           input logic e, input logic typed, input t_status st,
                           input int b, input int m);
        t_row row;
        row.req.req    = q;
        row.req.slot   = SLOT_W'(s);
        row.req.code   = c;
        row.req.en     = e;
        row.typed      = typed;
        row.ans.status = st;
        row.ans.button = BUTTON_W'(b);
        row.ans.slot   = SLOT_W'(m);
        dir_rows.push_back(row);
    endtask

    task automatic send_request(input t_request r, input logic typed, input t_answer given);
        t_answer a;
        while (!calm && $urandom_range(99) < 12) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid       = 1'b1;
        req_if.req_type    = r.req;
        req_if.slot_index  = r.slot;
        req_if.raw_code    = r.code;
        req_if.enable_flag = r.en;
        do begin
            @(posedge i_clk);
        end while (req_if.ready !== 1'b1);
        a = whitelist_answer(r);
        answer_q.push_back(typed ? given : a);
        n_sent++;
        if (r.req == REQ_CHECK) begin
            n_checks++;
            if (a.status == ST_OK) n_allowed++;
        end else if (r.req == REQ_LEARN) begin
            n_learns++;
        end else begin
            n_writes++;
        end
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        rsp_if.ready = calm || ($urandom_range(99) >= 12);
    end

    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        if (i_rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            got.status = rsp_if.status;
            got.button = rsp_if.button;
            got.slot   = rsp_if.matched_slot;
            if (answer_q.size() == 0) begin
                errors++;
                $display("%0t: response with none awaited: status=%0d button=%0d slot=%0d",
                         $time, got.status, got.button, got.slot);
            end else begin
                want = answer_q.pop_front();
                if (got.status !== want.status || got.button !== want.button ||
                    got.slot !== want.slot) begin
                    errors++;
                    $display("%0t: mismatch: expected status=%0d button=%0d slot=%0d, got status=%0d button=%0d slot=%0d",
                             $time, want.status, want.button, want.slot,
                             got.status, got.button, got.slot);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
            (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles, %0d responses outstanding",
                     $time, quiet_cycles, answer_q.size());
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        int k;
        i_rst_n            = 1'b0;
        req_if.valid       = 1'b0;
        req_if.req_type    = REQ_CHECK;
        req_if.slot_index  = '0;
        req_if.raw_code    = '0;
        req_if.enable_flag = 1'b0;
        rsp_if.ready       = 1'b0;
        for (k = 0; k < NSLOT; k++) begin
            tbl_base[k] = '0;
            tbl_on[k]   = 1'b0;
        end
        for (k = 0; k < POOL_SIZE; k++) begin
            base_pool[k] = pool_base(k);
        end

        add_row(REQ_CHECK,   0, 32'h0000_0011, 1'b0, 1'b1, ST_NOT_FOUND, 0, 0);
        add_row(REQ_CHECK,   0, 32'h0000_0000, 1'b0, 1'b1, ST_BAD_CODE,  0, 0);
        add_row(REQ_CHECK,   0, 32'h0000_0001, 1'b0, 1'b1, ST_BAD_CODE,  0, 0);
        add_row(REQ_CHECK,   0, 32'h0000_00C0, 1'b0, 1'b1, ST_BAD_CODE,  0, 0);
        add_row(REQ_CHECK,   0, 32'hFFFF_FFFF, 1'b1, 1'b1, ST_BAD_CODE,  0, 0);
        add_row(REQ_LEARN,   0, 32'hFFFF_FFF1, 1'b0, 1'b1, ST_OK,        0, 0);
        add_row(REQ_CHECK,   0, 32'hFFFF_FFF8, 1'b0, 1'b1, ST_OK,        4, 0);
        add_row(REQ_LEARN,  15, 32'hABCD_EFC0, 1'b0, 1'b1, ST_OK,        0, 0);
        add_row(REQ_CHECK,   0, 32'hABCD_EF03, 1'b0, 1'b1, ST_OK,        2, 15);
        add_row(REQ_CHECK,   0, 32'hABCD_EF0C, 1'b0, 1'b1, ST_OK,        3, 15);
        add_row(REQ_ENABLE, 15, 32'h0000_0000, 1'b0, 1'b1, ST_OK,        0, 0);
        add_row(REQ_CHECK,   0, 32'hABCD_EFC0, 1'b0, 1'b1, ST_DISABLED,  0, 0);
        add_row(REQ_LEARN,   3, 32'h0ABC_DEF2, 1'b0, 1'b0, ST_OK,        0, 0);
        add_row(REQ_CHECK,   0, 32'hABCD_EF30, 1'b0, 1'b0, ST_OK,        0, 0);
        add_row(REQ_ENABLE,  3, 32'h5A5A_5A5A, 1'b0, 1'b1, ST_OK,        0, 0);
        add_row(REQ_ENABLE, 15, 32'hA5A5_A5A5, 1'b1, 1'b1, ST_OK,        0, 0);
        add_row(REQ_CHECK,   0, 32'h0ABC_DEF4, 1'b0, 1'b1, ST_DISABLED,  0, 0);
        add_row(REQ_LEARN,   2, 32'h1234_5670, 1'b0, 1'b1, ST_BAD_CODE,  0, 0);
        add_row(REQ_ENABLE,  5, 32'h0000_0000, 1'b1, 1'b1, ST_OK,        0, 0);
        add_row(REQ_CHECK,   0, 32'h0000_0051, 1'b0, 1'b0, ST_OK,        0, 0);
        add_row(REQ_REMOVE,  0, 32'hFFFF_FFF1, 1'b1, 1'b1, ST_OK,        0, 0);
        add_row(REQ_CHECK,   0, 32'hFFFF_FFF1, 1'b0, 1'b1, ST_NOT_FOUND, 0, 0);
        add_row(REQ_LEARN,   7, 32'h0000_0031, 1'b0, 1'b0, ST_OK,        0, 0);
        add_row(REQ_CHECK,   9, 32'h0000_03C0, 1'b1, 1'b0, ST_OK,        0, 0);
        add_row(REQ_REMOVE, 15, 32'h0000_0000, 1'b0, 1'b0, ST_OK,        0, 0);

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (k = 0; k < dir_rows.size(); k++) begin
            send_request(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].ans);
        end
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            calm = (k >= 700 && k < 1000);
            if (k % 200 == 199) begin
                base_pool[(k / 200) % POOL_SIZE] = pool_base((k / 200) % POOL_SIZE);
            end
            send_request(random_request(), 1'b0, '0);
        end
        calm         = 1'b0;
        req_if.valid = 1'b0;

        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests: %0d checks (%0d allowed), %0d learns, %0d enable or remove.",
                 n_sent, n_checks, n_allowed, n_learns, n_writes);
        $display("Mismatched or unexpected responses: %0d.", errors);
        if (errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
